// ===== src/tlb_page_table_translator_top_assert.svh =====
// ----------------------------------------------------------------------------
// TLB page table translator assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef TLB_PAGE_TABLE_TRANSLATOR_TOP_ASSERT_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_TOP_ASSERT_SVH

// same-cycle implication
`define TLBPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tlbpt assertion failed");

// next-cycle implication
`define TLBPT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tlbpt assertion failed");

`endif

// ===== src/tlbpt_pkg.sv =====
// ----------------------------------------------------------------------------
// TLB page table translator package
// Field widths and the request/response bundles between the blocks.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

    localparam int VA_W    = 16;
    localparam int PAGE_W  = 8;
    localparam int FRAME_W = 8;
    localparam int CNT_W   = 32;

    typedef struct packed {
        logic               search;
        logic               resolve;
        logic               install;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } t_tlb_req;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
    } t_tlb_rsp;

    typedef struct packed {
        logic              read;
        logic              alloc;
        logic [PAGE_W-1:0] page;
    } t_pt_req;

    typedef struct packed {
        logic               mapped;
        logic [FRAME_W-1:0] frame;
    } t_pt_rsp;

endpackage

// ===== src/tlbpt_tlb.sv =====
// ----------------------------------------------------------------------------
// TLB
// Tag compare array with FIFO replacement and a frame memory read at the
// matching slot.
// ----------------------------------------------------------------------------
module tlbpt_tlb #(
    parameter int ENTRIES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tlbpt_pkg::t_tlb_req i_req,
    output tlbpt_pkg::t_tlb_rsp o_rsp
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [tlbpt_pkg::PAGE_W-1:0]  r_tag [ENTRIES];
    logic [tlbpt_pkg::FRAME_W-1:0] r_frame_mem [ENTRIES];
    logic [tlbpt_pkg::FRAME_W-1:0] r_rd_frame;
    logic [ENTRIES-1:0]            r_valid;
    logic [ENTRIES-1:0]            r_match;
    logic [IDX_W-1:0]              r_slot;
    logic [IDX_W-1:0]              n_slot;
    logic [IDX_W-1:0]              hit_idx;

    // lowest matching slot wins; at most one matches in practice
    always_comb begin
        hit_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign n_slot = (r_slot == IDX_W'(ENTRIES - 1)) ? '0 : r_slot + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_slot  <= '0;
        end else if (i_req.install) begin
            r_valid[r_slot] <= 1'b1;
            r_slot          <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.search) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_match[i] <= r_valid[i] && (r_tag[i] == i_req.page);
            end
        end
        if (i_req.install) begin
            r_tag[r_slot] <= i_req.page;
        end
    end

    // frame memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.install) begin
            r_frame_mem[r_slot] <= i_req.frame;
        end
        if (i_req.resolve) begin
            r_rd_frame <= r_frame_mem[hit_idx];
        end
    end

    always_comb begin
        o_rsp.hit   = |r_match;
        o_rsp.frame = r_rd_frame;
    end

endmodule

// ===== src/tlbpt_page_table.sv =====
// ----------------------------------------------------------------------------
// Page table
// Per-page mapped bits, frame memory and the free-frame allocator.
// ----------------------------------------------------------------------------
module tlbpt_page_table #(
    parameter int PAGES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tlbpt_pkg::t_pt_req i_req,
    output tlbpt_pkg::t_pt_rsp o_rsp
);

    localparam int IDX_W = $clog2(PAGES);
    localparam int NF_W  = $clog2(PAGES + 1);

    logic [tlbpt_pkg::FRAME_W-1:0] r_mem [PAGES];
    logic [tlbpt_pkg::FRAME_W-1:0] r_rd_frame;
    logic                          r_rd_mapped;
    logic [PAGES-1:0]              r_valid;
    logic [NF_W-1:0]               r_next_free;
    logic [IDX_W-1:0]              idx;
    logic [tlbpt_pkg::FRAME_W-1:0] alloc_frame;

    assign idx         = i_req.page[IDX_W-1:0];
    assign alloc_frame = tlbpt_pkg::FRAME_W'(r_next_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_next_free <= '0;
        end else if (i_req.alloc) begin
            r_valid[idx] <= 1'b1;
            if (r_next_free < NF_W'(PAGES)) begin
                r_next_free <= r_next_free + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.read) begin
            r_rd_mapped <= r_valid[idx];
            r_rd_frame  <= r_mem[idx];
        end
        if (i_req.alloc) begin
            r_mem[idx] <= alloc_frame;
        end
    end

    // unmapped pages take the next free frame
    always_comb begin
        o_rsp.mapped = r_rd_mapped;
        o_rsp.frame  = r_rd_mapped ? r_rd_frame : alloc_frame;
    end

endmodule

// ===== src/tlb_page_table_translator_top.sv =====
// Sequence: the start beat leads through SEARCH, RESOLVE and DONE to o_valid;
// DIV and MOD reduce the page number first if PAGE_COUNT is not a power of 2.
// Addresses are taken only in idle; busy drops in the strobe cycle.
// Path: TLB tag compare and page table read, then TLB frame memory read.
// Reset: synchronous, clears TLB and page table valid bits, FIFO pointer,
// free-frame pointer and counters. The receiver cannot stall.
// ----------------------------------------------------------------------------
// TLB page table translator top
// Virtual to physical translation with FIFO TLB and on-demand frame mapping.
// ----------------------------------------------------------------------------
`include "tlb_page_table_translator_top_assert.svh"

module tlb_page_table_translator_top #(
    parameter int TLB_ENTRIES  = 16,
    parameter int PAGE_COUNT   = 256,
    parameter int OFFSET_WIDTH = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tlbpt_pkg::VA_W-1:0]    i_virtual_address,
    output logic                          o_valid,
    output logic [tlbpt_pkg::VA_W-1:0]    o_physical_address,
    output logic                          o_tlb_hit,
    output logic                          o_page_fault,
    output logic [tlbpt_pkg::PAGE_W-1:0]  o_fault_page,
    output logic [tlbpt_pkg::CNT_W-1:0]   o_translated_count,
    output logic [tlbpt_pkg::CNT_W-1:0]   o_fault_count,
    output logic [tlbpt_pkg::CNT_W-1:0]   o_hit_count
);

    localparam int VPN_W   = tlbpt_pkg::VA_W - OFFSET_WIDTH;
    localparam bit PAGE_POW2 = ((PAGE_COUNT & (PAGE_COUNT - 1)) == 0);
    localparam logic [VPN_W-1:0] VPN_MASK = VPN_W'(PAGE_COUNT - 1);
    // exact reciprocal for vpn < 2**VPN_W
    localparam int SH = VPN_W + $clog2(PAGE_COUNT);
    localparam int MW = VPN_W + 2;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SH) + PAGE_COUNT - 1) / PAGE_COUNT;
    localparam logic [MW-1:0] RECIP = MW'(RECIP_FULL);
    localparam int PW = VPN_W + MW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MOD,
        S_SEARCH,
        S_RESOLVE,
        S_DONE
    } t_state;

    t_state                        r_state;
    logic [tlbpt_pkg::VA_W-1:0]    r_va;
    logic [VPN_W-1:0]              r_quot;
    logic [tlbpt_pkg::PAGE_W-1:0]  r_page;
    logic                          r_hit;
    logic                          r_fault;
    logic [tlbpt_pkg::FRAME_W-1:0] r_miss_frame;
    logic [tlbpt_pkg::CNT_W-1:0]   r_total_cnt;
    logic [tlbpt_pkg::CNT_W-1:0]   r_fault_cnt;
    logic [tlbpt_pkg::CNT_W-1:0]   r_hit_cnt;

    logic [VPN_W-1:0]              vpn_in;
    logic [VPN_W-1:0]              vpn;
    logic [PW-1:0]                 prod;
    logic [VPN_W+8:0]              qmul;
    logic [VPN_W-1:0]              rem;
    logic [tlbpt_pkg::FRAME_W-1:0] frame;
    logic                          alloc;

    tlbpt_pkg::t_tlb_req tlb_req;
    tlbpt_pkg::t_tlb_rsp tlb_rsp;
    tlbpt_pkg::t_pt_req  pt_req;
    tlbpt_pkg::t_pt_rsp  pt_rsp;

    function automatic logic [tlbpt_pkg::CNT_W-1:0] sat_inc(
        input logic [tlbpt_pkg::CNT_W-1:0] v
    );
        return (&v) ? v : v + 1'b1;
    endfunction

    assign vpn_in = i_virtual_address[tlbpt_pkg::VA_W-1:OFFSET_WIDTH];
    assign vpn    = r_va[tlbpt_pkg::VA_W-1:OFFSET_WIDTH];
    assign prod   = PW'(vpn) * PW'(RECIP);
    assign qmul   = (VPN_W + 9)'(r_quot) * (VPN_W + 9)'(PAGE_COUNT);
    assign rem    = vpn - qmul[VPN_W-1:0];
    assign frame  = r_hit ? tlb_rsp.frame : r_miss_frame;
    assign alloc  = (r_state == S_RESOLVE) && !tlb_rsp.hit && !pt_rsp.mapped;
    assign busy   = (r_state != S_IDLE);

    always_comb begin
        tlb_req.search  = (r_state == S_SEARCH);
        tlb_req.resolve = (r_state == S_RESOLVE);
        tlb_req.install = (r_state == S_RESOLVE) && !tlb_rsp.hit;
        tlb_req.page    = r_page;
        tlb_req.frame   = pt_rsp.frame;
        pt_req.read     = (r_state == S_SEARCH);
        pt_req.alloc    = alloc;
        pt_req.page     = r_page;
    end

    tlbpt_tlb #(
        .ENTRIES(TLB_ENTRIES)
    ) u_tlb (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (tlb_req),
        .o_rsp  (tlb_rsp)
    );

    tlbpt_page_table #(
        .PAGES(PAGE_COUNT)
    ) u_page_table (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (pt_req),
        .o_rsp  (pt_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_valid     <= 1'b0;
            r_total_cnt <= '0;
            r_fault_cnt <= '0;
            r_hit_cnt   <= '0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_va    <= i_virtual_address;
                        r_page  <= tlbpt_pkg::PAGE_W'(vpn_in & VPN_MASK);
                        r_state <= PAGE_POW2 ? S_SEARCH : S_DIV;
                    end
                end
                S_DIV: begin
                    r_quot  <= VPN_W'(prod >> SH);
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    r_page  <= tlbpt_pkg::PAGE_W'(rem);
                    r_state <= S_SEARCH;
                end
                S_SEARCH: begin
                    r_state <= S_RESOLVE;
                end
                S_RESOLVE: begin
                    r_hit        <= tlb_rsp.hit;
                    r_fault      <= alloc;
                    r_miss_frame <= pt_rsp.frame;
                    r_total_cnt  <= sat_inc(r_total_cnt);
                    if (tlb_rsp.hit) begin
                        r_hit_cnt <= sat_inc(r_hit_cnt);
                    end
                    if (alloc) begin
                        r_fault_cnt <= sat_inc(r_fault_cnt);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    o_valid            <= 1'b1;
                    o_physical_address <= tlbpt_pkg::VA_W'({frame, r_va[OFFSET_WIDTH-1:0]});
                    o_tlb_hit          <= r_hit;
                    o_page_fault       <= r_fault;
                    o_fault_page       <= r_fault ? r_page : '0;
                    o_translated_count <= r_total_cnt;
                    o_fault_count      <= r_fault_cnt;
                    o_hit_count        <= r_hit_cnt;
                    r_state            <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `TLBPT_ASSERT_IMP(a_hit_xor_fault, i_clk, i_rst_n, o_valid, !(o_tlb_hit && o_page_fault))
    `TLBPT_ASSERT_IMP(a_hit_counted, i_clk, i_rst_n, o_valid && o_tlb_hit, o_hit_count != '0)
    `TLBPT_ASSERT_NXT(a_start_leaves_idle, i_clk, i_rst_n, i_rst_n && start && !busy, busy)
    `TLBPT_ASSERT_IMP(a_strobe_after_done, i_clk, i_rst_n, o_valid, $past(r_state == S_DONE))

endmodule
